// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the range-sum tree modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define RSST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never hold outside reset
`define RSST_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg
// Types and constants shared by the range-sum segment tree controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package rsst_pkg;

	// default number of leaves the node store is sized for
	localparam int MAX_LEAVES_DEF = 1024;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_LEAF,
		ST_SET_UP,
		ST_QUERY,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture the accepted item
		logic clr;       // clear one node of the store
		logic set_leaf;  // write the leaf, read its sibling
		logic set_up;    // write one parent sum, read the next sibling
		logic q_walk;    // one level of the range walk
		logic out_load;  // move the result into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic bad;       // incoming item is out of range
		logic mode;      // incoming item is a query
		logic idx_root;  // current node is the root
		logic up_last;   // parent being written is the root
		logic q_more;    // range walk still has nodes left
		logic clr_last;  // clearing pass is at the last node
	} sts_t;

endpackage

// ===== rtl/range_sum_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_sum_segment_tree
// Bottom-up segment tree of wrapping 32-bit sums with leaf set and
// half-open range query items.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: item_valid/item_stall with mode, left_pos, right_bound,
//   new_value; mode 0 sets a leaf, mode 1 queries [left_pos, right_bound).
//   result channel: result_valid/result_stall with range_sum and status;
//   exactly one result per item, status 1 marks an ignored out-of-range item.
//   cfg_wr_en/cfg_wr_data write the leaf count (clamped to 1..MAX_LEAVES), idle only.
// Sequence of an item after its transfer:
//   set item: the leaf write, then one store write per level up to the root.
//   query: one walk step per level until the range is used up; two
//   store reads per level, summed in the cycle after.
//   rejected item: straight to the result. One item in flight at a time, so the next item
//   transfers at the earliest on the edge where the last result can.
// Reset: the node store is cleared by a pass over all 2 * MAX_LEAVES nodes (2048 at
//   the default) with item_stall high; configuration writes are taken meanwhile.
// Stall: the result register holds while result_stall is high; the next item
//   is taken meanwhile and waits for the register before it finishes.
// ----------------------------------------------------------------------------
module range_sum_segment_tree #(
	parameter int MAX_LEAVES = rsst_pkg::MAX_LEAVES_DEF,
	localparam int POS_W = $clog2(MAX_LEAVES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [POS_W-1:0]   cfg_wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic [POS_W-1:0]   left_pos,
	input  logic [POS_W-1:0]   right_bound,
	input  logic signed [31:0] new_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] range_sum,
	output logic               status
);

	rsst_pkg::cmd_t cmd;
	rsst_pkg::sts_t sts;

	// sequencer
	rsst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// node store and arithmetic
	rsst_dp #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mode        (mode),
		.left_pos    (left_pos),
		.right_bound (right_bound),
		.new_value   (new_value),
		.range_sum   (range_sum),
		.status      (status)
	);

endmodule

// ===== rtl/rsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsst_ctrl
// Sequencer for the range-sum tree: clearing pass after reset, item accept,
// leaf update walk, range query walk and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	output logic           result_valid,
	input  logic           result_stall,
	input  rsst_pkg::sts_t sts,
	output rsst_pkg::cmd_t cmd
);

	rsst_pkg::state_t state_q;
	rsst_pkg::state_t state_nx;
	logic             result_valid_q;
	logic [5:0]       cmd_vec;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			rsst_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_nx = rsst_pkg::ST_IDLE;
				end
			end
			rsst_pkg::ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (sts.bad) begin
						state_nx = rsst_pkg::ST_FINISH;
					end else if (sts.mode) begin
						state_nx = rsst_pkg::ST_QUERY;
					end else begin
						state_nx = rsst_pkg::ST_SET_LEAF;
					end
				end
			end
			rsst_pkg::ST_SET_LEAF: begin
				cmd.set_leaf = 1'b1;
				state_nx = sts.idx_root ? rsst_pkg::ST_FINISH : rsst_pkg::ST_SET_UP;
			end
			rsst_pkg::ST_SET_UP: begin
				cmd.set_up = 1'b1;
				if (sts.up_last) begin
					state_nx = rsst_pkg::ST_FINISH;
				end
			end
			rsst_pkg::ST_QUERY: begin
				// last pending reads are summed on the exit edge
				if (sts.q_more) begin
					cmd.q_walk = 1'b1;
				end else begin
					state_nx = rsst_pkg::ST_FINISH;
				end
			end
			rsst_pkg::ST_FINISH: begin
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_nx = rsst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = rsst_pkg::ST_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != rsst_pkg::ST_IDLE);
	assign result_valid = result_valid_q;

	assign cmd_vec = {cmd.load, cmd.clr, cmd.set_leaf, cmd.set_up, cmd.q_walk, cmd.out_load};

	`RSST_ASSERT(a_one_cmd, $onehot0(cmd_vec), "more than one datapath command at once")
	`RSST_ASSERT(a_clear_once, (state_q != rsst_pkg::ST_CLEAR) |=> (state_q != rsst_pkg::ST_CLEAR),
		"clearing pass re-entered outside reset")
	`RSST_ASSERT(a_result_from_finish, $rose(result_valid_q) |-> $past(state_q == rsst_pkg::ST_FINISH),
		"result raised without a finished item")

endmodule

// ===== rtl/rsst_dp.sv =====
// ----------------------------------------------------------------------------
// rsst_dp
// Datapath of the range-sum tree: node store with one write and two
// registered read ports, leaf count register, walk pointers, accumulator and
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsst_dp #(
	parameter int MAX_LEAVES = rsst_pkg::MAX_LEAVES_DEF,
	localparam int POS_W  = $clog2(MAX_LEAVES + 1),
	localparam int DEPTH  = 2 * MAX_LEAVES,
	localparam int NODE_W = $clog2(DEPTH),
	localparam int PTR_W  = NODE_W + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rsst_pkg::cmd_t          cmd,
	output rsst_pkg::sts_t          sts,
	input  logic                    cfg_wr_en,
	input  logic [POS_W-1:0]        cfg_wr_data,
	input  logic                    mode,
	input  logic [POS_W-1:0]        left_pos,
	input  logic [POS_W-1:0]        right_bound,
	input  logic signed [31:0]      new_value,
	output logic signed [31:0]      range_sum,
	output logic                    status
);

	logic [31:0]       mem [DEPTH];
	logic [31:0]       rd_a_q;
	logic [31:0]       rd_b_q;
	logic [POS_W-1:0]  n_q;
	logic [POS_W-1:0]  cfg_n;
	logic [PTR_W-1:0]  idx_q;
	logic [PTR_W-1:0]  hi_q;
	logic [31:0]       cur_q;
	logic [31:0]       acc_q;
	logic              pend_a_q;
	logic              pend_b_q;
	logic              bad_q;
	logic [NODE_W-1:0] clr_cnt_q;
	logic [31:0]       sum_q;
	logic              status_q;
	logic              bad;
	logic [NODE_W-1:0] parent;
	logic [31:0]       up_sum;
	logic [PTR_W-1:0]  lo_nx;
	logic [PTR_W-1:0]  hi_nx;
	logic [PTR_W-1:0]  hi_m1;
	logic              wr_en;
	logic [NODE_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	logic [NODE_W-1:0] rd_a_addr;
	logic [NODE_W-1:0] rd_b_addr;

	// leaf count clamped into 1 .. MAX_LEAVES on write
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_n = POS_W'(1);
		end else if (cfg_wr_data > POS_W'(MAX_LEAVES)) begin
			cfg_n = POS_W'(MAX_LEAVES);
		end else begin
			cfg_n = cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= POS_W'(MAX_LEAVES);
		end else if (cfg_wr_en) begin
			n_q <= cfg_n;
		end
	end

	// range check of the incoming item
	assign bad = mode ? ((left_pos > n_q) || (right_bound > n_q)) : (left_pos >= n_q);

	// walk arithmetic
	assign parent = idx_q[PTR_W-1:1];
	assign up_sum = cur_q + rd_a_q;
	assign lo_nx  = idx_q + PTR_W'(idx_q[0]);
	assign hi_nx  = hi_q - PTR_W'(hi_q[0]);
	assign hi_m1  = hi_q - PTR_W'(1);

	// store port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = '0;
		if (cmd.clr) begin
			wr_en = 1'b1;
		end else if (cmd.set_leaf) begin
			wr_en   = 1'b1;
			wr_addr = idx_q[NODE_W-1:0];
			wr_data = cur_q;
		end else if (cmd.set_up) begin
			wr_en   = 1'b1;
			wr_addr = parent;
			wr_data = up_sum;
		end
	end

	always_comb begin
		if (cmd.set_leaf) begin
			rd_a_addr = idx_q[NODE_W-1:0] ^ NODE_W'(1);
		end else if (cmd.set_up) begin
			rd_a_addr = parent ^ NODE_W'(1);
		end else begin
			rd_a_addr = idx_q[NODE_W-1:0];
		end
	end
	assign rd_b_addr = hi_m1[NODE_W-1:0];

	// node store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + NODE_W'(1);
		end
	end

	// walk pointers and pending read flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
		end else begin
			pend_a_q <= cmd.q_walk & idx_q[0];
			pend_b_q <= cmd.q_walk & hi_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= PTR_W'(n_q) + PTR_W'(left_pos);
			hi_q  <= PTR_W'(n_q) + PTR_W'(right_bound);
			cur_q <= $unsigned(new_value);
			bad_q <= bad;
		end else if (cmd.set_up) begin
			idx_q <= {1'b0, parent};
			cur_q <= up_sum;
		end else if (cmd.q_walk) begin
			idx_q <= {1'b0, lo_nx[PTR_W-1:1]};
			hi_q  <= {1'b0, hi_nx[PTR_W-1:1]};
		end
	end

	// accumulator takes the nodes read on the previous walk step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_q + (pend_a_q ? rd_a_q : 32'd0) + (pend_b_q ? rd_b_q : 32'd0);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sum_q    <= acc_q;
			status_q <= bad_q;
		end
	end

	assign range_sum = $signed(sum_q);
	assign status    = status_q;

	// status to controller
	assign sts.bad      = bad;
	assign sts.mode     = mode;
	assign sts.idx_root = (idx_q == PTR_W'(1));
	assign sts.up_last  = (parent == NODE_W'(1));
	assign sts.q_more   = (idx_q < hi_q);
	assign sts.clr_last = (clr_cnt_q == NODE_W'(DEPTH - 1));

	`RSST_NEVER(a_no_node0_write, wr_en && !cmd.clr && (wr_addr == '0),
		"tree update wrote the unused node zero")

endmodule

// ===== dv/range_sum_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_tb_pkg
// Item and result codes shared by the range-sum tree testbench and its
// checker.
// ----------------------------------------------------------------------------
package range_sum_tb_pkg;

	// item kinds
	localparam logic MODE_SET   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result status
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

endpackage

// ===== dv/range_sum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_checker
// Watches the item, result and configuration ports of the range-sum tree,
// keeps its own copy of the node store and leaf count, predicts the result
// of every item transfer and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module range_sum_checker #(
	parameter int MAX_LEAVES = rsst_pkg::MAX_LEAVES_DEF,
	parameter int POS_W = $clog2(MAX_LEAVES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [POS_W-1:0]   cfg_wr_data,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic               mode,
	input  logic [POS_W-1:0]   left_pos,
	input  logic [POS_W-1:0]   right_bound,
	input  logic signed [31:0] new_value,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [31:0] range_sum,
	input  logic               status,
	output int                 fail_count,
	output int                 outstanding
);
	import range_sum_tb_pkg::*;

	localparam int NODES = 2 * MAX_LEAVES;

	typedef struct {
		logic [31:0] sum;
		logic        flag;
		int unsigned item_no;
	} sum_result_t;

	logic [31:0]      node_sum [0:NODES-1];
	logic [POS_W-1:0] leaf_count;
	sum_result_t      pending_sums [$];
	int unsigned      items_seen;

	// leaf count as the tree uses it, saturated to 1..MAX_LEAVES
	function automatic int unsigned leaves_in_use();
		int unsigned n = 32'(leaf_count);
		if (n < 1) n = 1;
		if (n > MAX_LEAVES) n = MAX_LEAVES;
		return n;
	endfunction

	// write a leaf and redo the sums up to the root
	function automatic void store_leaf(int unsigned n, int unsigned pos, logic [31:0] value);
		int unsigned i;
		i = n + pos;
		node_sum[i] = value;
		while (i > 1) begin
			node_sum[i >> 1] = node_sum[i] + node_sum[i ^ 1];
			i = i >> 1;
		end
	endfunction

	// wrapping sum over leaves [lo, hi)
	function automatic logic [31:0] sum_over(int unsigned n, int unsigned lo, int unsigned hi);
		logic [31:0] acc;
		acc = '0;
		lo += n;
		hi += n;
		while (lo < hi) begin
			if (lo & 1) begin
				acc += node_sum[lo];
				lo++;
			end
			if (hi & 1) begin
				hi--;
				acc += node_sum[hi];
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		$display("range_sum_checker: %s", msg);
	endtask

	// predict on item transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		sum_result_t want;
		int unsigned n;
		int unsigned lo_u;
		int unsigned hi_u;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				node_sum[i] = '0;
			leaf_count = POS_W'(MAX_LEAVES);
			pending_sums.delete();
			items_seen = 0;
			outstanding <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				n = leaves_in_use();
				lo_u = 32'(left_pos);
				hi_u = 32'(right_bound);
				want.sum = '0;
				want.flag = STATUS_OK;
				want.item_no = items_seen;
				if (mode == MODE_SET) begin
					if (lo_u >= n)
						want.flag = STATUS_RANGE;
					else
						store_leaf(n, lo_u, new_value);
				end else if (lo_u > n || hi_u > n) begin
					want.flag = STATUS_RANGE;
				end else begin
					want.sum = sum_over(n, lo_u, hi_u);
				end
				pending_sums.push_back(want);
				items_seen++;
			end

			if (result_valid && !result_stall) begin
				if (pending_sums.size() == 0) begin
					report_mismatch($sformatf("result with no item waiting: sum %h status %b",
						range_sum, status));
				end else begin
					want = pending_sums.pop_front();
					if (range_sum !== want.sum)
						report_mismatch($sformatf("item %0d: range_sum %h, expected %h",
							want.item_no, range_sum, want.sum));
					if (status !== want.flag)
						report_mismatch($sformatf("item %0d: status %b, expected %b",
							want.item_no, status, want.flag));
				end
			end

			// a new leaf count applies from the next edge on
			if (cfg_wr_en)
				leaf_count = cfg_wr_data;

			outstanding <= pending_sums.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the range-sum tree with directed set and query items around the
// bounds, then random phases at several leaf counts, with random gaps on
// both channels, a long result hold-off and a stretch without gaps. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import rsst_pkg::*;
	import range_sum_tb_pkg::*;

	localparam int LEAVES = MAX_LEAVES_DEF;
	localparam int POS_W = $clog2(LEAVES + 1);
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int HOLD_PHASE = 2;
	localparam int CALM_PHASE = 5;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_CYCLES = 32;
	localparam longint TIMEOUT_NS = 3_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [POS_W-1:0]   cfg_wr_data;
	logic               item_valid;
	logic               item_stall;
	logic               mode;
	logic [POS_W-1:0]   left_pos;
	logic [POS_W-1:0]   right_bound;
	logic signed [31:0] new_value;
	logic               result_valid;
	logic               result_stall;
	logic signed [31:0] range_sum;
	logic               status;

	logic               calm;
	logic               hold_req;
	int                 fail_count;
	int                 outstanding;
	int unsigned        leaves;

	range_sum_segment_tree #(.MAX_LEAVES(LEAVES)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.left_pos     (left_pos),
		.right_bound  (right_bound),
		.new_value    (new_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.range_sum    (range_sum),
		.status       (status)
	);

	range_sum_checker #(.MAX_LEAVES(LEAVES)) sum_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.left_pos     (left_pos),
		.right_bound  (right_bound),
		.new_value    (new_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.range_sum    (range_sum),
		.status       (status),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("tb: timeout");
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		logic hold_seen;
		hold_seen = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req !== hold_seen) begin
				hold_seen = hold_req;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= !calm && ($urandom_range(0, 99) < 29);
		end
	end

	// offer one item after a random gap and wait for its transfer
	task automatic send_item(input logic op, input int unsigned lo,
			input int unsigned hi, input logic [31:0] value);
		if (!calm) begin
			while ($urandom_range(0, 99) < 29) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		mode <= op;
		left_pos <= POS_W'(lo);
		right_bound <= POS_W'(hi);
		new_value <= value;
		do @(posedge clk); while (item_stall);
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_for_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// leaf count write, only while the tree is idle
	task automatic write_leaf_count(input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= POS_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		leaves = (value == 0) ? 1 : (value > LEAVES) ? LEAVES : value;
	endtask

	// stimulus and verdict
	initial begin
		int unsigned phase_cfg [10];
		int unsigned roll;
		int unsigned lo;
		int unsigned hi;
		int counted;
		logic [31:0] value;

		phase_cfg = '{1024, 2, 37, 1, 2047, 300, 0, 512, 5, 1025};
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		item_valid <= 1'b0;
		mode <= MODE_SET;
		left_pos <= '0;
		right_bound <= '0;
		new_value <= '0;
		calm <= 1'b0;
		hold_req <= 1'b0;
		leaves = LEAVES;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// extreme values at the first and last leaf, default leaf count
		send_item(MODE_SET, 0, 0, 32'h7FFF_FFFF);
		send_item(MODE_SET, LEAVES - 1, POS_MAX, 32'h8000_0000);
		send_item(MODE_SET, 5, 0, 32'hFFFF_FFFF);
		send_item(MODE_SET, 512, 0, 32'h0000_0001);
		// set beyond the leaves
		send_item(MODE_SET, LEAVES, 0, 32'h1234_5678);
		send_item(MODE_SET, POS_MAX, POS_MAX, 32'hFFFF_FFFF);
		// full range, single leaves, wrapping sum
		send_item(MODE_QUERY, 0, LEAVES, 32'hFFFF_FFFF);
		send_item(MODE_QUERY, 5, 6, 0);
		send_item(MODE_QUERY, LEAVES - 1, LEAVES, 0);
		send_item(MODE_QUERY, 0, 6, 0);
		// empty and reversed ranges
		send_item(MODE_QUERY, 0, 0, 0);
		send_item(MODE_QUERY, LEAVES, LEAVES, 0);
		send_item(MODE_QUERY, 10, 3, 0);
		// bounds beyond the leaves
		send_item(MODE_QUERY, 0, LEAVES + 1, 0);
		send_item(MODE_QUERY, LEAVES + 1, 0, 0);
		send_item(MODE_QUERY, POS_MAX, POS_MAX, 0);

		// zero leaf count saturates to one leaf over the old contents
		wait_for_results();
		write_leaf_count(0);
		send_item(MODE_QUERY, 0, 1, 0);
		send_item(MODE_SET, 0, 0, 32'h5555_5555);
		send_item(MODE_SET, 1, 0, 32'h0000_0007);
		send_item(MODE_QUERY, 0, 1, 0);
		send_item(MODE_QUERY, 1, 1, 0);
		send_item(MODE_QUERY, 0, 2, 0);

		// oversized leaf count saturates to the full tree
		wait_for_results();
		write_leaf_count(POS_MAX);
		send_item(MODE_QUERY, 0, LEAVES, 0);
		send_item(MODE_SET, LEAVES - 1, 0, 32'hAAAA_AAAA);
		send_item(MODE_QUERY, 1, LEAVES, 0);

		// random phases, each at its own leaf count
		for (int phase = 0; phase < 10; phase++) begin
			wait_for_results();
			write_leaf_count(phase_cfg[phase]);
			calm <= (phase == CALM_PHASE);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				case ($urandom_range(0, 7))
					0: value = 32'h7FFF_FFFF;
					1: value = 32'h8000_0000;
					2: value = 32'hFFFF_FFFF;
					3: value = 32'h0000_0000;
					default: value = $urandom();
				endcase
				if (roll < 45) begin
					send_item(MODE_SET, $urandom_range(0, leaves - 1), $urandom_range(0, POS_MAX),
						value);
					counted++;
				end else if (roll < 90) begin
					lo = $urandom_range(0, leaves);
					hi = (roll < 84) ? $urandom_range(lo, leaves) : $urandom_range(0, lo);
					send_item(MODE_QUERY, lo, hi, value);
					counted++;
				end else begin
					send_item(1'($urandom_range(0, 1)), $urandom_range(0, POS_MAX),
						$urandom_range(0, POS_MAX), value);
				end
				// long result hold-off while items keep coming
				if (phase == HOLD_PHASE && counted == 20 && roll < 90)
					hold_req <= ~hold_req;
			end
		end

		wait_for_results();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$display("tb: %0d results never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== range_sum_segment_tree.f =====
+incdir+rtl
rtl/rsst_pkg.sv
rtl/rsst_ctrl.sv
rtl/rsst_dp.sv
rtl/range_sum_segment_tree.sv
dv/range_sum_tb_pkg.sv
dv/range_sum_checker.sv
dv/tb.sv
